@@ src/axis_threshold_crossing_counter_macros.svh @@
// ----------------------------------------------------------------------------
// axis threshold crossing counter assertion macros
// Concurrent assertion helpers sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_THRESHOLD_CROSSING_COUNTER_MACROS_SVH
`define AXIS_THRESHOLD_CROSSING_COUNTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ATCC_ASSERT_IMPL(lbl, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("atcc same-cycle check failed");

// next-cycle implication
`define ATCC_ASSERT_NEXT(lbl, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("atcc next-cycle check failed");

`else

`define ATCC_ASSERT_IMPL(lbl, lhs, rhs)
`define ATCC_ASSERT_NEXT(lbl, lhs, rhs)

`endif

`endif

@@ src/atcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcc_pkg
// Shared types and constants of the axis threshold crossing counter.
// ----------------------------------------------------------------------------
package atcc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THR_W       = 15;
    localparam int STEP_W      = 8;
    localparam int CAL_CNT_W   = 8;
    localparam int CAL_SUM_W   = 25;
    localparam int VALUE_W     = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int DIV_W       = 24;
    localparam int DIV_CNT_W   = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_XY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_Z  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES  = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0]     RST_THRESHOLD_XY = 15'd8350;
    localparam logic [THR_W-1:0]     RST_THRESHOLD_Z  = 15'd5010;
    localparam logic [STEP_W-1:0]    RST_STEP_SIZE    = 8'd5;
    localparam logic [CAL_CNT_W-1:0] RST_CAL_SAMPLES  = 8'd100;

    // axis select codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_DIV,
        ST_AXIS,
        ST_RESULT
    } state_t;

endpackage

@@ src/atcc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcc_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module atcc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [atcc_pkg::DIV_W-1:0]        dividend,
    input  logic [atcc_pkg::CAL_CNT_W-1:0]    divisor,
    output logic                              done,
    output logic [atcc_pkg::DIV_W-1:0]        quotient
);
    import atcc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]       quot_reg;
    logic [CAL_CNT_W-1:0]   rem_reg;
    logic [CAL_CNT_W-1:0]   div_reg;

    logic [CAL_CNT_W:0]     rem_shift;
    logic [CAL_CNT_W:0]     rem_diff;
    logic                   fits;
    logic [CAL_CNT_W-1:0]   rem_next;
    logic [DIV_W-1:0]       quot_next;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        fits      = rem_shift >= {1'b0, div_reg};
        // remainder stays below the divisor, so 8 bits hold it
        rem_next  = fits ? rem_diff[CAL_CNT_W-1:0] : rem_shift[CAL_CNT_W-1:0];
        quot_next = {quot_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_STEP)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ src/atcc_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcc_axis
// One-axis crossing update: band compare, latch and saturating step.
// ----------------------------------------------------------------------------
module atcc_axis #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic signed [atcc_pkg::VALUE_W-1:0] value,
    input  logic        [atcc_pkg::THR_W-1:0]   threshold,
    input  logic        [atcc_pkg::STEP_W-1:0]  step,
    input  logic signed [COUNT_WIDTH-1:0]       count_in,
    input  logic                                latched_in,
    output logic signed [COUNT_WIDTH-1:0]       count_out,
    output logic                                latched_out
);
    import atcc_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + STEP_W + 1;
    localparam logic signed [SUM_W-1:0] CNT_MAX =
        {{(STEP_W + 2){1'b0}}, {(COUNT_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] CNT_MIN = ~CNT_MAX;

    logic signed [VALUE_W-1:0] thr_pos;
    logic signed [VALUE_W-1:0] thr_neg;
    logic signed [SUM_W-1:0]   count_ext;
    logic signed [SUM_W-1:0]   step_ext;
    logic signed [SUM_W-1:0]   sum_up;
    logic signed [SUM_W-1:0]   sum_dn;
    logic signed [COUNT_WIDTH-1:0] sat_up;
    logic signed [COUNT_WIDTH-1:0] sat_dn;

    always_comb
    begin
        thr_pos   = $signed({2'b00, threshold});
        thr_neg   = -thr_pos;
        count_ext = SUM_W'(count_in);
        step_ext  = $signed({{(SUM_W - STEP_W){1'b0}}, step});
        sum_up    = count_ext + step_ext;
        sum_dn    = count_ext - step_ext;
        sat_up    = (sum_up > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX) : COUNT_WIDTH'(sum_up);
        sat_dn    = (sum_dn < CNT_MIN) ? COUNT_WIDTH'(CNT_MIN) : COUNT_WIDTH'(sum_dn);
    end

    always_comb
    begin
        count_out   = count_in;
        latched_out = latched_in;
        priority if (value > thr_pos && !latched_in)
        begin
            count_out   = sat_up;
            latched_out = 1'b1;
        end
        else if (value < thr_neg && !latched_in)
        begin
            count_out   = sat_dn;
            latched_out = 1'b1;
        end
        else if (value > thr_neg && value < thr_pos)
        begin
            // back strictly inside the band: re-arm
            latched_out = 1'b0;
        end
        else
        begin
            // on a band edge, or latched and still outside: hold
            latched_out = latched_in;
        end
    end

endmodule

@@ src/axis_threshold_crossing_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_threshold_crossing_counter
// Per-axis threshold crossing counters with Z offset calibration.
// ----------------------------------------------------------------------------
// monitor beat: one shared axis unit visits X, Y, Z in turn, then the result
//   stage loads; no new sample is taken until the block is back in idle
// calibration beat: adds raw Z to the running sum; the beat that closes a
//   calibration run also runs the 24-step restoring divider to form the offset
// async active-low reset: counters, latches, offset and calibration cleared,
//   registers at their defaults
// ----------------------------------------------------------------------------
`include "axis_threshold_crossing_counter_macros.svh"

module axis_threshold_crossing_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [atcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [atcc_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic                                  action,
    input  logic signed [atcc_pkg::SAMPLE_W-1:0]  raw_x,
    input  logic signed [atcc_pkg::SAMPLE_W-1:0]  raw_y,
    input  logic signed [atcc_pkg::SAMPLE_W-1:0]  raw_z,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [atcc_pkg::SAMPLE_W-1:0]  count_x,
    output logic signed [atcc_pkg::SAMPLE_W-1:0]  count_y,
    output logic signed [atcc_pkg::SAMPLE_W-1:0]  count_z,
    output logic signed [atcc_pkg::SAMPLE_W-1:0]  offset_z,
    output logic                                  cal_done
);
    import atcc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [THR_W-1:0]     thr_xy_reg;
    logic [THR_W-1:0]     thr_z_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [CAL_CNT_W-1:0] cal_samples_reg;

    // held item
    logic signed [SAMPLE_W-1:0] raw_x_reg;
    logic signed [SAMPLE_W-1:0] raw_y_reg;
    logic signed [SAMPLE_W-1:0] raw_z_reg;

    // block state
    logic signed [COUNT_WIDTH-1:0] counter_x_reg;
    logic signed [COUNT_WIDTH-1:0] counter_y_reg;
    logic signed [COUNT_WIDTH-1:0] counter_z_reg;
    logic [2:0]                    latched_reg;
    logic signed [SAMPLE_W-1:0]    z_offset_reg;
    logic signed [CAL_SUM_W-1:0]   cal_sum_reg;
    logic [CAL_CNT_W-1:0]          cal_count_reg;
    logic                          done_flag_reg;
    logic [1:0]                    axis_idx_reg;

    // result stage
    logic                          result_valid_reg;
    logic signed [SAMPLE_W-1:0]    res_count_x_reg;
    logic signed [SAMPLE_W-1:0]    res_count_y_reg;
    logic signed [SAMPLE_W-1:0]    res_count_z_reg;
    logic signed [SAMPLE_W-1:0]    res_offset_reg;
    logic                          res_done_reg;

    // control
    logic sample_take;
    logic div_start;
    logic div_done;
    logic axis_we;
    logic load_result;

    // calibration datapath
    logic signed [CAL_SUM_W-1:0] cal_sum_next;
    logic signed [CAL_SUM_W-1:0] cal_sum_neg;
    logic [CAL_CNT_W-1:0]        cal_count_next;
    logic                        cal_end;
    logic [DIV_W-1:0]            cal_mag;
    logic [DIV_W-1:0]            div_quot;
    logic signed [SAMPLE_W-1:0]  z_offset_next;

    // shared axis unit
    logic signed [VALUE_W-1:0]     sel_value;
    logic [THR_W-1:0]              sel_thr;
    logic signed [COUNT_WIDTH-1:0] sel_count;
    logic                          sel_latched;
    logic signed [COUNT_WIDTH-1:0] axis_count;
    logic                          axis_latched;

    assign cfg_ready   = 1'b1;
    assign sample_take = sample_valid && sample_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (sample_valid)
                    state_next = action ? ST_CAL : ST_AXIS;
            ST_CAL:
                state_next = cal_end ? ST_DIV : ST_RESULT;
            ST_DIV:
                if (div_done)
                    state_next = ST_RESULT;
            ST_AXIS:
                if (axis_idx_reg == AXIS_Z)
                    state_next = ST_RESULT;
            ST_RESULT:
                if (!result_valid_reg || result_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_ready = 1'b0;
        div_start    = 1'b0;
        axis_we      = 1'b0;
        load_result  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   sample_ready = 1'b1;
            ST_CAL:    div_start    = cal_end;
            ST_DIV:    ;
            ST_AXIS:   axis_we      = 1'b1;
            ST_RESULT: load_result  = !result_valid_reg || result_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_xy_reg      <= RST_THRESHOLD_XY;
            thr_z_reg       <= RST_THRESHOLD_Z;
            step_reg        <= RST_STEP_SIZE;
            cal_samples_reg <= RST_CAL_SAMPLES;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD_XY: thr_xy_reg      <= cfg_data;
                CFG_THRESHOLD_Z:  thr_z_reg       <= cfg_data;
                CFG_STEP_SIZE:    step_reg        <= cfg_data[STEP_W-1:0];
                CFG_CAL_SAMPLES:  cal_samples_reg <= cfg_data[CAL_CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            raw_x_reg <= raw_x;
            raw_y_reg <= raw_y;
            raw_z_reg <= raw_z;
        end
    end

    // calibration accumulate and offset
    always_comb
    begin
        cal_sum_next   = cal_sum_reg + CAL_SUM_W'(raw_z_reg);
        cal_sum_neg    = -cal_sum_next;
        cal_count_next = cal_count_reg + 1'b1;
        cal_end        = cal_count_next >= cal_samples_reg;
        cal_mag        = cal_sum_next[CAL_SUM_W-1] ? cal_sum_neg[DIV_W-1:0]
                                                   : cal_sum_next[DIV_W-1:0];
        // mean magnitude is at most 32768, which negates cleanly in 16 bits
        z_offset_next  = cal_sum_reg[CAL_SUM_W-1] ? ~div_quot[SAMPLE_W-1:0] + 1'b1
                                                  : div_quot[SAMPLE_W-1:0];
    end

    atcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cal_mag),
        .divisor  (cal_count_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_reg   <= '0;
            cal_count_reg <= '0;
            z_offset_reg  <= '0;
            done_flag_reg <= 1'b0;
        end
        else
        begin
            if (sample_take)
                done_flag_reg <= 1'b0;
            if (state_reg == ST_CAL)
            begin
                cal_sum_reg   <= cal_sum_next;
                cal_count_reg <= cal_count_next;
            end
            else if (state_reg == ST_DIV && div_done)
            begin
                z_offset_reg  <= z_offset_next;
                cal_sum_reg   <= '0;
                cal_count_reg <= '0;
                done_flag_reg <= 1'b1;
            end
        end
    end

    // axis operand select
    always_comb
    begin
        sel_value   = '0;
        sel_thr     = '0;
        sel_count   = '0;
        sel_latched = 1'b0;
        unique case (axis_idx_reg)
            AXIS_X:
            begin
                sel_value   = VALUE_W'(raw_x_reg);
                sel_thr     = thr_xy_reg;
                sel_count   = counter_x_reg;
                sel_latched = latched_reg[0];
            end
            AXIS_Y:
            begin
                sel_value   = VALUE_W'(raw_y_reg);
                sel_thr     = thr_xy_reg;
                sel_count   = counter_y_reg;
                sel_latched = latched_reg[1];
            end
            AXIS_Z:
            begin
                sel_value   = VALUE_W'(raw_z_reg) - VALUE_W'(z_offset_reg);
                sel_thr     = thr_z_reg;
                sel_count   = counter_z_reg;
                sel_latched = latched_reg[2];
            end
            default: ;
        endcase
    end

    atcc_axis #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_axis (
        .value       (sel_value),
        .threshold   (sel_thr),
        .step        (step_reg),
        .count_in    (sel_count),
        .latched_in  (sel_latched),
        .count_out   (axis_count),
        .latched_out (axis_latched)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_x_reg <= '0;
            counter_y_reg <= '0;
            counter_z_reg <= '0;
            latched_reg   <= '0;
            axis_idx_reg  <= AXIS_X;
        end
        else
        begin
            if (sample_take)
                axis_idx_reg <= AXIS_X;
            else if (axis_we)
                axis_idx_reg <= axis_idx_reg + 1'b1;

            if (axis_we)
            begin
                unique case (axis_idx_reg)
                    AXIS_X:
                    begin
                        counter_x_reg  <= axis_count;
                        latched_reg[0] <= axis_latched;
                    end
                    AXIS_Y:
                    begin
                        counter_y_reg  <= axis_count;
                        latched_reg[1] <= axis_latched;
                    end
                    AXIS_Z:
                    begin
                        counter_z_reg  <= axis_count;
                        latched_reg[2] <= axis_latched;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_result)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            res_count_x_reg <= SAMPLE_W'(counter_x_reg);
            res_count_y_reg <= SAMPLE_W'(counter_y_reg);
            res_count_z_reg <= SAMPLE_W'(counter_z_reg);
            res_offset_reg  <= z_offset_reg;
            res_done_reg    <= done_flag_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign count_x      = res_count_x_reg;
    assign count_y      = res_count_y_reg;
    assign count_z      = res_count_z_reg;
    assign offset_z     = res_offset_reg;
    assign cal_done     = res_done_reg;

    `ATCC_ASSERT_NEXT(a_div_done_to_result, (state_reg == ST_DIV) && div_done, state_reg == ST_RESULT)
    `ATCC_ASSERT_IMPL(a_cal_cleared_on_done, (state_reg == ST_RESULT) && done_flag_reg, cal_count_reg == '0)
    `ATCC_ASSERT_IMPL(a_axis_idx_range, state_reg == ST_AXIS, axis_idx_reg != 2'd3)
    `ATCC_ASSERT_NEXT(a_take_leaves_idle, sample_take, state_reg != ST_IDLE)

endmodule
